/* rtl/setna_pkg.sv */
// Package for the sorted event table: widths, operation codes, controller states, time conversion.
package setna_pkg;

  localparam int MaxEvents = 32;
  localparam int SlotW = 5;
  localparam int LinkW = 6;
  localparam int TimeW = 33;
  localparam int TagW = 32;
  localparam int SecW = 40;
  localparam logic [LinkW-1:0] NoneLink = LinkW'(MaxEvents);

  typedef enum logic [2:0] {
    OP_CLEAR  = 3'd0,
    OP_INSERT = 3'd1,
    OP_REMOVE = 3'd2,
    OP_PEEK   = 3'd3,
    OP_ALARM  = 3'd4
  } op_t;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_CLEAR,
    ST_DISPATCH,
    ST_WALK_RD,
    ST_WALK_CHK,
    ST_INS_LINK,
    ST_REM_LINK,
    ST_PEEK_RD,
    ST_PEEK_OUT,
    ST_FINISH,
    ST_OUT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // capture the request
    logic clear;      // restore the pool
    logic clr_step;   // one step of the link sweep
    logic walk_init;  // start a walk at the head of the used list
    logic rd_cur;     // read record and link of the current slot
    logic walk_adv;   // move to the next slot
    logic ins_commit; // link and write the new event
    logic rem_commit; // unlink the removed slot
    logic peek_rd;    // read the addressed slot
    logic fin_ok;     // set the result flag
    logic alarm_hit;  // record the alarm for the current slot
    logic out_load;   // fill the output register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    op_t  op;
    logic clr_done;
    logic cur_valid;
    logic ins_stop;   // current start later than the key
    logic rem_found;  // current slot is the one to remove
    logic alarm_ended;
    logic can_insert;
    logic id_used;
  } sts_t;

  // Packed calendar time to a signed second count (30-day months, 360-day years).
  function automatic logic signed [SecW-1:0] to_seconds(input logic [TimeW-1:0] t);
    logic signed [SecW-1:0] acc;
    acc = SecW'(t[5:0]) + SecW'(t[11:6]) * 60 + SecW'(t[16:12]) * 3600
        + (SecW'(t[21:17]) - 1) * 86400 + (SecW'(t[25:22]) - 1) * 2592000
        + SecW'(t[32:26]) * 31104000;
    return acc;
  endfunction

endpackage

/* rtl/setna_ctrl.sv */
// Controller state machine of the sorted event table.
module setna_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  output logic            out_valid,
  input  logic            out_stall,
  input  setna_pkg::sts_t sts,
  output setna_pkg::cmd_t cmd
);
  import setna_pkg::*;

  state_t state_r, state_nxt;
  logic [LinkW-1:0] guard_r, guard_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_INIT;
      guard_r <= '0;
    end else begin
      state_r <= state_nxt;
      guard_r <= guard_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    guard_nxt = guard_r;
    unique case (state_r)
      ST_INIT: if (sts.clr_done) state_nxt = ST_IDLE;
      ST_IDLE: if (in_valid) state_nxt = ST_DISPATCH;
      ST_DISPATCH: begin
        guard_nxt = '0;
        unique case (sts.op)
          OP_CLEAR: state_nxt = ST_CLEAR;
          OP_INSERT: state_nxt = sts.can_insert ? ST_WALK_RD : ST_FINISH;
          OP_REMOVE: state_nxt = sts.id_used ? ST_WALK_RD : ST_FINISH;
          OP_PEEK: state_nxt = ST_PEEK_RD;
          OP_ALARM: state_nxt = ST_WALK_RD;
          default: state_nxt = ST_FINISH;
        endcase
      end
      ST_CLEAR: if (sts.clr_done) state_nxt = ST_FINISH;
      ST_WALK_RD: begin
        if (!sts.cur_valid || guard_r == LinkW'(MaxEvents)) begin
          state_nxt = (sts.op == OP_INSERT) ? ST_INS_LINK : ST_FINISH;
        end else begin
          state_nxt = ST_WALK_CHK;
        end
      end
      ST_WALK_CHK: begin
        guard_nxt = guard_r + 1'b1;
        state_nxt = ST_WALK_RD;
        if (sts.op == OP_INSERT && sts.ins_stop) state_nxt = ST_INS_LINK;
        if (sts.op == OP_REMOVE && sts.rem_found) state_nxt = ST_REM_LINK;
        if (sts.op == OP_ALARM && !sts.alarm_ended) state_nxt = ST_FINISH;
      end
      ST_INS_LINK: state_nxt = ST_FINISH;
      ST_REM_LINK: state_nxt = ST_FINISH;
      ST_PEEK_RD: state_nxt = ST_PEEK_OUT;
      ST_PEEK_OUT: state_nxt = ST_FINISH;
      ST_FINISH: state_nxt = ST_OUT;
      ST_OUT: if (!out_stall) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_stall = (state_r != ST_IDLE);
    out_valid = (state_r == ST_OUT);
    unique case (state_r)
      ST_INIT: cmd.clr_step = 1'b1;
      ST_IDLE: cmd.load = in_valid;
      ST_DISPATCH: begin
        cmd.walk_init = 1'b1;
        cmd.clear = (sts.op == OP_CLEAR);
      end
      ST_CLEAR: cmd.clr_step = 1'b1;
      ST_WALK_RD: cmd.rd_cur = 1'b1;
      ST_WALK_CHK: begin
        // Keep the current slot on the read port so its link is still there
        // when a removal splices it out.
        cmd.rd_cur = 1'b1;
        if (sts.op == OP_ALARM && !sts.alarm_ended) cmd.alarm_hit = 1'b1;
        else if (!(sts.op == OP_INSERT && sts.ins_stop) &&
                 !(sts.op == OP_REMOVE && sts.rem_found)) cmd.walk_adv = 1'b1;
      end
      ST_INS_LINK: begin
        cmd.ins_commit = 1'b1;
        cmd.fin_ok = 1'b1;
      end
      ST_REM_LINK: begin
        cmd.rem_commit = 1'b1;
        cmd.fin_ok = 1'b1;
      end
      ST_PEEK_RD: cmd.peek_rd = 1'b1;
      ST_PEEK_OUT: begin
        cmd.peek_rd = 1'b1;
        cmd.fin_ok = sts.id_used;
      end
      ST_FINISH: cmd.out_load = 1'b1;
      default: ;
    endcase
    if (state_r == ST_CLEAR && sts.clr_done) cmd.fin_ok = 1'b1;
  end

endmodule

/* rtl/setna_dp.sv */
// Datapath of the sorted event table: link pool, event records and result register.
module setna_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  setna_pkg::cmd_t               cmd,
  output setna_pkg::sts_t               sts,
  input  logic [2:0]                    in_operation,
  input  logic [setna_pkg::SlotW-1:0]   in_slot_id,
  input  logic [setna_pkg::TimeW-1:0]   in_start_time,
  input  logic [setna_pkg::TimeW-1:0]   in_end_time,
  input  logic [setna_pkg::TagW-1:0]    in_start_tag,
  input  logic [setna_pkg::TagW-1:0]    in_end_tag,
  input  logic [setna_pkg::TimeW-1:0]   in_now_time,
  output logic                          out_ok,
  output logic [setna_pkg::SlotW-1:0]   out_result_slot,
  output logic [setna_pkg::TimeW-1:0]   out_start_time,
  output logic [setna_pkg::TimeW-1:0]   out_end_time,
  output logic [setna_pkg::TagW-1:0]    out_start_tag,
  output logic [setna_pkg::TagW-1:0]    out_end_tag,
  output logic [setna_pkg::TimeW-1:0]   out_alarm_time,
  output logic                          out_alarm_is_end,
  output logic                          out_running_valid,
  output logic [setna_pkg::SlotW-1:0]   out_running_slot,
  output logic [setna_pkg::LinkW-1:0]   out_event_count
);
  import setna_pkg::*;

  localparam int RecW = 2 * TimeW + 2 * TagW;

  // Event records and links live in memories; used bits are flip-flops.
  logic [RecW-1:0]  rec_mem [MaxEvents];
  logic [LinkW-1:0] link_mem [MaxEvents];
  logic [MaxEvents-1:0] used_r;

  logic [2:0] op_r;
  logic [SlotW-1:0] id_r;
  logic [TimeW-1:0] st_r, en_r;
  logic [TagW-1:0] stag_r, etag_r;
  logic signed [SecW-1:0] key_r;
  logic [LinkW-1:0] head_r, free_r, count_r, run_r, clr_r, slot_r;
  logic [LinkW-1:0] cur_r, prev_r;
  logic [RecW-1:0] rec_q;
  logic [LinkW-1:0] link_q;
  logic [LinkW-1:0] prev_link_r;
  logic ok_r;
  logic alarm_r, alarm_end_r;
  logic [TimeW-1:0] alarm_time_r;
  logic [SlotW-1:0] alarm_slot_r;

  logic [TimeW-1:0] q_start, q_end;
  logic signed [SecW-1:0] q_start_s, q_end_s;
  logic q_ready_r;

  // Link of the free head, captured when the request is dispatched.
  logic [LinkW-1:0] link_q_free_r;

  assign q_start = rec_q[RecW-1 -: TimeW];
  assign q_end = rec_q[RecW-TimeW-1 -: TimeW];

  // Memory write port: one address per cycle.
  logic lw_en;
  logic [SlotW-1:0] lw_addr;
  logic [LinkW-1:0] lw_data;

  always_comb begin
    lw_en = 1'b0;
    lw_addr = '0;
    lw_data = '0;
    if (cmd.clr_step) begin
      lw_en = 1'b1;
      lw_addr = clr_r[SlotW-1:0];
      lw_data = clr_r + 1'b1;
    end else if (cmd.ins_commit) begin
      lw_en = 1'b1;
      lw_addr = slot_r[SlotW-1:0];
      lw_data = (prev_r == NoneLink) ? head_r : prev_link_r;
    end else if (cmd.rem_commit) begin
      lw_en = 1'b1;
      lw_addr = id_r;
      lw_data = free_r;
    end
  end

  // Second link write port: the predecessor's link gets the new slot on an
  // insert, or the successor of the removed slot on a removal.
  logic pw_en;
  logic [SlotW-1:0] pw_addr;
  logic [LinkW-1:0] pw_data;
  assign pw_en = (cmd.ins_commit || cmd.rem_commit) && prev_r != NoneLink;
  assign pw_addr = prev_r[SlotW-1:0];
  assign pw_data = cmd.ins_commit ? slot_r : link_q;

  always_ff @(posedge clk) begin
    if (lw_en) link_mem[lw_addr] <= lw_data;
    if (pw_en) link_mem[pw_addr] <= pw_data;
    if (cmd.ins_commit) rec_mem[slot_r[SlotW-1:0]] <= {st_r, en_r, stag_r, etag_r};
  end

  logic [SlotW-1:0] rd_addr;
  assign rd_addr = cmd.peek_rd ? id_r :
                   (cmd.rd_cur ? cur_r[SlotW-1:0] : free_r[SlotW-1:0]);

  always_ff @(posedge clk) begin
    rec_q <= rec_mem[rd_addr];
    link_q <= link_mem[rd_addr];
  end

  // Second counts of the record that was just read.
  assign q_start_s = to_seconds(q_start);
  assign q_end_s = to_seconds(q_end);

  logic signed [SecW-1:0] now_s_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r <= in_operation;
      id_r <= in_slot_id;
      st_r <= in_start_time;
      en_r <= in_end_time;
      stag_r <= in_start_tag;
      etag_r <= in_end_tag;
      key_r <= to_seconds(in_start_time);
      now_s_r <= to_seconds(in_now_time);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
      head_r <= NoneLink;
      free_r <= '0;
      count_r <= '0;
      run_r <= NoneLink;
      clr_r <= '0;
      cur_r <= NoneLink;
      prev_r <= NoneLink;
      slot_r <= '0;
      ok_r <= 1'b0;
      alarm_r <= 1'b0;
      alarm_end_r <= 1'b0;
      q_ready_r <= 1'b0;
    end else begin
      q_ready_r <= cmd.rd_cur;
      if (cmd.load) begin
        ok_r <= 1'b0;
        alarm_r <= 1'b0;
        alarm_end_r <= 1'b0;
        clr_r <= '0;
      end
      if (cmd.clear) begin
        used_r <= '0;
        head_r <= NoneLink;
        free_r <= '0;
        count_r <= '0;
        run_r <= NoneLink;
      end
      if (cmd.clr_step) clr_r <= clr_r + 1'b1;
      if (cmd.walk_init) begin
        cur_r <= head_r;
        prev_r <= NoneLink;
        slot_r <= free_r;
        if (op_r == OP_ALARM) run_r <= NoneLink;
      end
      if (cmd.walk_adv) begin
        prev_r <= cur_r;
        prev_link_r <= link_q;
        cur_r <= link_q;
      end
      if (cmd.alarm_hit) begin
        ok_r <= 1'b1;
        alarm_r <= 1'b1;
        alarm_slot_r <= cur_r[SlotW-1:0];
        if (now_s_r >= q_start_s) begin
          run_r <= cur_r;
          alarm_end_r <= 1'b1;
          alarm_time_r <= q_end;
        end else begin
          alarm_time_r <= q_start;
        end
      end
      if (cmd.fin_ok) ok_r <= 1'b1;
      if (cmd.ins_commit) begin
        head_r <= (prev_r == NoneLink) ? slot_r : head_r;
        free_r <= link_q_free_r;
        used_r[slot_r[SlotW-1:0]] <= 1'b1;
        count_r <= count_r + 1'b1;
      end
      if (cmd.rem_commit) begin
        if (prev_r == NoneLink) head_r <= link_q;
        free_r <= {1'b0, id_r};
        used_r[id_r] <= 1'b0;
        count_r <= count_r - 1'b1;
        if (run_r == {1'b0, id_r}) run_r <= NoneLink;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.walk_init) link_q_free_r <= link_mem[free_r[SlotW-1:0]];
  end

  // The last link of the sweep ends the pool.
  logic [LinkW-1:0] clr_last_fix;
  assign clr_last_fix = clr_r;

  always_comb begin
    sts.op = op_t'(op_r);
    sts.clr_done = (clr_last_fix == LinkW'(MaxEvents - 1));
    sts.cur_valid = (cur_r != NoneLink);
    sts.ins_stop = q_ready_r && (q_start_s > key_r);
    sts.rem_found = (cur_r == {1'b0, id_r});
    sts.alarm_ended = !q_ready_r || (now_s_r >= q_end_s);
    sts.can_insert = (count_r < LinkW'(MaxEvents)) && (free_r != NoneLink);
    sts.id_used = used_r[id_r];
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_ok <= ok_r;
      out_result_slot <= '0;
      out_start_time <= '0;
      out_end_time <= '0;
      out_start_tag <= '0;
      out_end_tag <= '0;
      out_alarm_time <= '0;
      out_alarm_is_end <= alarm_end_r;
      out_running_valid <= (run_r != NoneLink);
      out_running_slot <= (run_r != NoneLink) ? run_r[SlotW-1:0] : '0;
      out_event_count <= count_r;
      unique case (op_r)
        OP_INSERT: if (ok_r) out_result_slot <= slot_r[SlotW-1:0];
        OP_REMOVE: out_result_slot <= id_r;
        OP_PEEK: begin
          out_result_slot <= id_r;
          if (ok_r) begin
            out_start_time <= rec_q[RecW-1 -: TimeW];
            out_end_time <= rec_q[RecW-TimeW-1 -: TimeW];
            out_start_tag <= rec_q[2*TagW-1 -: TagW];
            out_end_tag <= rec_q[TagW-1:0];
          end
        end
        OP_ALARM: if (alarm_r) begin
          out_result_slot <= alarm_slot_r;
          out_alarm_time <= alarm_time_r;
        end
        default: ;
      endcase
    end
  end

  property p_count_max;
    @(posedge clk) disable iff (!rst_n) count_r <= LinkW'(MaxEvents);
  endproperty
  a_count_max: assert property (p_count_max) else $error("event count above pool size");

  property p_count_used;
    @(posedge clk) disable iff (!rst_n) count_r == LinkW'($countones(used_r));
  endproperty
  a_count_used: assert property (p_count_used) else $error("event count and used bits differ");

  property p_head_empty;
    @(posedge clk) disable iff (!rst_n) (head_r == NoneLink) == (count_r == '0);
  endproperty
  a_head_empty: assert property (p_head_empty) else $error("list head and event count differ");

endmodule

/* rtl/sorted_event_table_next_alarm.sv */
// Top level of the sorted event table with next-alarm query.
//
//  Port group | Direction | Handshake
//  in_*       | input     | in_valid / in_stall
//  out_*      | output    | out_valid / out_stall
//
// One item at a time. Clear sweeps the 32 links, one a cycle.
// Insert, remove and alarm walk the sorted list slot by slot, reading and then
// checking each slot through the link memory read port; peek reads one slot.
// Reset is synchronous; after it the controller rebuilds the free chain with a
// sweep of all 32 links, during which in_stall stays high.
// While the result waits under out_stall, no new item is taken.
module sorted_event_table_next_alarm (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [2:0]                    in_operation,
  input  logic [setna_pkg::SlotW-1:0]   in_slot_id,
  input  logic [setna_pkg::TimeW-1:0]   in_start_time,
  input  logic [setna_pkg::TimeW-1:0]   in_end_time,
  input  logic [setna_pkg::TagW-1:0]    in_start_tag,
  input  logic [setna_pkg::TagW-1:0]    in_end_tag,
  input  logic [setna_pkg::TimeW-1:0]   in_now_time,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_ok,
  output logic [setna_pkg::SlotW-1:0]   out_result_slot,
  output logic [setna_pkg::TimeW-1:0]   out_start_time,
  output logic [setna_pkg::TimeW-1:0]   out_end_time,
  output logic [setna_pkg::TagW-1:0]    out_start_tag,
  output logic [setna_pkg::TagW-1:0]    out_end_tag,
  output logic [setna_pkg::TimeW-1:0]   out_alarm_time,
  output logic                          out_alarm_is_end,
  output logic                          out_running_valid,
  output logic [setna_pkg::SlotW-1:0]   out_running_slot,
  output logic [setna_pkg::LinkW-1:0]   out_event_count
);
  import setna_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // The controller sequences each transfer; the datapath holds the pool.
  setna_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .sts(sts), .cmd(cmd)
  );

  setna_dp u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .in_operation(in_operation), .in_slot_id(in_slot_id),
    .in_start_time(in_start_time), .in_end_time(in_end_time),
    .in_start_tag(in_start_tag), .in_end_tag(in_end_tag), .in_now_time(in_now_time),
    .out_ok(out_ok), .out_result_slot(out_result_slot),
    .out_start_time(out_start_time), .out_end_time(out_end_time),
    .out_start_tag(out_start_tag), .out_end_tag(out_end_tag),
    .out_alarm_time(out_alarm_time), .out_alarm_is_end(out_alarm_is_end),
    .out_running_valid(out_running_valid), .out_running_slot(out_running_slot),
    .out_event_count(out_event_count)
  );

  property p_one_side;
    @(posedge clk) disable iff (!rst_n) out_valid |-> in_stall;
  endproperty
  a_one_side: assert property (p_one_side) else $error("input taken while result pending");

  property p_hold;
    @(posedge clk) disable iff (!rst_n) out_valid && out_stall |=> out_valid;
  endproperty
  a_hold: assert property (p_hold) else $error("result dropped under stall");

  property p_count;
    @(posedge clk) disable iff (!rst_n) out_valid |-> out_event_count <= 6'd32;
  endproperty
  a_count: assert property (p_count) else $error("event count out of range");

endmodule
